@@ hw/rtl/bca_pkg.sv @@
// ----------------------------------------------------------------------------
// bca_pkg
// shared sizes, codes and types of the bitmap contiguous allocator
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int MAP_UNITS = 1024;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = (MAP_UNITS + WORD_BITS - 1) / WORD_BITS;

  // bits the scan unit walks through in one cycle
  localparam int CHUNK_BITS = (WORD_BITS % 8 == 0) ? 8 :
                              (WORD_BITS % 4 == 0) ? 4 :
                              (WORD_BITS % 2 == 0) ? 2 : 1;
  localparam int CHUNKS_PER_WORD = WORD_BITS / CHUNK_BITS;

  // fixed field widths
  localparam int SIZE_W   = 11;
  localparam int WIDX_IN_W = 4;
  localparam int DATA_W   = 64;
  localparam int START_W  = 10;
  localparam int PTR_W    = 11;

  // derived widths
  localparam int UNIT_W = $clog2(MAP_UNITS);
  localparam int LEN_W  = $clog2(MAP_UNITS + 1);
  localparam int POS_W  = LEN_W + 1;
  localparam int CW     = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
  localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CIDX_W = (CHUNKS_PER_WORD > 1) ? $clog2(CHUNKS_PER_WORD) : 1;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_LOAD  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_LOADED  = 2'd2
  } status_e;

  // running state of a hole search
  typedef struct packed {
    logic [CW-1:0]     run_len;
    logic [UNIT_W-1:0] run_start;
    logic [CW-1:0]     pick_len;
    logic [UNIT_W-1:0] pick_start;
    logic              have;
    logic              found;
  } scan_state_t;

  // one cycle of map memory traffic
  typedef struct packed {
    logic                 we;
    logic [WIDX_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [WIDX_W-1:0]    raddr;
  } mem_req_t;

endpackage

@@ hw/rtl/bca_map_mem.sv @@
// ----------------------------------------------------------------------------
// bca_map_mem
// used-bit map: one write and one registered read per cycle, words that were
// never written read as free
// ----------------------------------------------------------------------------
module bca_map_mem
  import bca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mem_req_t             req_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_q;
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= valid_q[req_i.raddr] ? mem[req_i.raddr] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bca_scan_unit.sv @@
// ----------------------------------------------------------------------------
// bca_scan_unit
// shared hole search step: advances the search over one chunk of map bits
// ----------------------------------------------------------------------------
module bca_scan_unit
  import bca_pkg::*;
(
  input  scan_state_t           state_i,
  input  logic [CHUNK_BITS-1:0] used_i,
  input  logic [POS_W-1:0]      base_i,
  input  logic [POS_W-1:0]      lo_i,
  input  logic [CW-1:0]         size_i,
  input  policy_e               policy_i,
  output scan_state_t           state_o
);

  scan_state_t      st;
  logic [POS_W-1:0] u;
  logic             free_b;
  logic             first_like;
  logic             better;

  always_comb begin
    st         = state_i;
    u          = '0;
    free_b     = 1'b0;
    better     = 1'b0;
    first_like = (policy_i == POL_FIRST) || (policy_i == POL_NEXT);
    for (int k = 0; k < CHUNK_BITS; k++) begin
      u      = base_i + POS_W'(k);
      // units below the start point or past the map act as used
      free_b = !used_i[k] && (u >= lo_i) && (u < POS_W'(MAP_UNITS));
      if (!st.found) begin
        if (free_b) begin
          if (st.run_len == '0) begin
            st.run_start = u[UNIT_W-1:0];
          end
          st.run_len = st.run_len + 1'b1;
          if (first_like && (st.run_len == size_i)) begin
            st.found      = 1'b1;
            st.pick_start = st.run_start;
          end
        end else begin
          better = !st.have ||
                   ((policy_i == POL_BEST) && (st.run_len < st.pick_len)) ||
                   ((policy_i == POL_WORST) && (st.run_len > st.pick_len));
          if ((st.run_len >= size_i) && better) begin
            st.have       = 1'b1;
            st.pick_len   = st.run_len;
            st.pick_start = st.run_start;
          end
          st.run_len = '0;
        end
      end
    end
    state_o = st;
  end

endmodule

@@ hw/rtl/bitmap_contiguous_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_contiguous_allocator_top
// contiguous run allocator over a used-bit map with first, best, worst and
// next fit placement
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// request   in         start && !busy            req_type_i, alloc_size_i,
//                                                word_index_i, word_data_i
// result    out        done_o, one cycle         status_o, start_unit_o
// config    in         cfg_valid_i && cfg_ready_o cfg_data_i (fit policy)
//
// a load request writes its map word at acceptance, the result follows in the
// next cycle and the block is free again at once
// an allocate request scans the map one word at a time: a fetch state reads
// the word, then a scan step handles each 8-bit chunk; a full scan covers all
// 16 words, plus a closing step when no run completed during the scan; first
// and next fit stop at the chunk where the run completes
// the grant is then written back with a read and a write state per word that
// the run touches, and a read state alone per word below the run
// a zero size or a next fit pointer past the map answers in the next cycle
// reset clears the map (valid bits per word), the next pointer and the
// policy; the result cannot be stalled, it is shown for exactly one cycle
// ----------------------------------------------------------------------------
module bitmap_contiguous_allocator_top
  import bca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type_i,
  input  logic [SIZE_W-1:0]    alloc_size_i,
  input  logic [WIDX_IN_W-1:0] word_index_i,
  input  logic [DATA_W-1:0]    word_data_i,
  // result
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [START_W-1:0]   start_unit_o,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_FIN,
    S_MARK_RD,
    S_MARK_WR
  } state_e;

  state_e               state_q;
  policy_e              fit_policy_q;
  policy_e              pol_q;
  logic [CW-1:0]        size_q;
  logic [POS_W-1:0]     lo_q;
  logic [WIDX_W-1:0]    word_q;
  logic [CIDX_W-1:0]    chunk_q;
  logic [POS_W-1:0]     unit_q;
  scan_state_t          st_q;
  scan_state_t          st_next;
  logic [UNIT_W-1:0]    grant_q;
  logic [POS_W-1:0]     end_q;
  logic [POS_W-1:0]     wbase_q;
  logic [PTR_W-1:0]     next_ptr_q;
  logic                 done_q;
  status_e              status_q;
  logic [START_W-1:0]   start_unit_q;

  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rdata;
  logic [CHUNK_BITS-1:0] chunk_used;
  logic [WORD_BITS-1:0] mark_mask;
  logic [POS_W-1:0]     mark_u;
  logic                 accept;
  logic                 is_load;
  logic                 load_in_map;
  logic [UNIT_W-1:0]    found_start;
  logic                 scan_done;

  assign accept      = start && !busy;
  assign is_load     = (req_e'(req_type_i) == REQ_LOAD);
  assign load_in_map = (32'(word_index_i) < MAP_WORDS);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // map memory traffic
  always_comb begin
    mem_req       = '0;
    mem_req.waddr = word_q;
    mem_req.wdata = rdata | mark_mask;
    mem_req.raddr = word_q;
    unique case (state_q)
      S_IDLE: begin
        mem_req.we    = accept && is_load && load_in_map;
        mem_req.waddr = WIDX_W'(word_index_i);
        mem_req.wdata = word_data_i[WORD_BITS-1:0];
      end
      S_FETCH:   mem_req.re = 1'b1;
      S_MARK_RD: mem_req.re = (wbase_q + POS_W'(WORD_BITS)) > POS_W'(grant_q);
      S_MARK_WR: mem_req.we = 1'b1;
      default: ;
    endcase
  end

  bca_map_mem u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // the closing step sees an all-used chunk, which ends the last hole
  assign chunk_used = (state_q == S_FIN) ? '1 : rdata[chunk_q*CHUNK_BITS +: CHUNK_BITS];

  bca_scan_unit u_scan (
    .state_i  (st_q),
    .used_i   (chunk_used),
    .base_i   (unit_q),
    .lo_i     (lo_q),
    .size_i   (size_q),
    .policy_i (pol_q),
    .state_o  (st_next)
  );

  assign found_start = st_next.pick_start;
  assign scan_done   = (chunk_q == CIDX_W'(CHUNKS_PER_WORD - 1)) &&
                       (word_q == WIDX_W'(MAP_WORDS - 1));

  // bits of the current mark word that fall inside the granted run
  always_comb begin
    mark_u = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      mark_u       = wbase_q + POS_W'(j);
      mark_mask[j] = (mark_u >= POS_W'(grant_q)) && (mark_u < end_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fit_policy_q <= POL_FIRST;
      pol_q        <= POL_FIRST;
      size_q       <= '0;
      lo_q         <= '0;
      word_q       <= '0;
      chunk_q      <= '0;
      unit_q       <= '0;
      st_q         <= '0;
      grant_q      <= '0;
      end_q        <= '0;
      wbase_q      <= '0;
      next_ptr_q   <= '0;
      done_q       <= 1'b0;
      status_q     <= ST_NOSPACE;
      start_unit_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        fit_policy_q <= policy_e'(cfg_data_i);
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (is_load) begin
              done_q       <= 1'b1;
              status_q     <= ST_LOADED;
              start_unit_q <= '0;
            end else if ((alloc_size_i == '0) ||
                         ((fit_policy_q == POL_NEXT) &&
                          (32'(next_ptr_q) >= MAP_UNITS))) begin
              // nothing to search
              done_q       <= 1'b1;
              status_q     <= ST_NOSPACE;
              start_unit_q <= '0;
              if (fit_policy_q == POL_NEXT) begin
                next_ptr_q <= '0;
              end
            end else begin
              pol_q   <= fit_policy_q;
              size_q  <= CW'(alloc_size_i);
              lo_q    <= (fit_policy_q == POL_NEXT) ? POS_W'(next_ptr_q) : '0;
              word_q  <= '0;
              chunk_q <= '0;
              unit_q  <= '0;
              st_q    <= '0;
              state_q <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          st_q   <= st_next;
          unit_q <= unit_q + POS_W'(CHUNK_BITS);
          if (st_next.found) begin
            grant_q <= found_start;
            end_q   <= POS_W'(32'(found_start) + 32'(size_q));
            word_q  <= '0;
            wbase_q <= '0;
            if (pol_q == POL_NEXT) begin
              next_ptr_q <= PTR_W'(32'(found_start) + 32'(size_q));
            end
            state_q <= S_MARK_RD;
          end else if (scan_done) begin
            state_q <= S_FIN;
          end else if (chunk_q == CIDX_W'(CHUNKS_PER_WORD - 1)) begin
            chunk_q <= '0;
            word_q  <= word_q + 1'b1;
            state_q <= S_FETCH;
          end else begin
            chunk_q <= chunk_q + 1'b1;
          end
        end
        S_FIN: begin
          if (st_next.have && ((pol_q == POL_BEST) || (pol_q == POL_WORST))) begin
            grant_q <= found_start;
            end_q   <= POS_W'(32'(found_start) + 32'(size_q));
            word_q  <= '0;
            wbase_q <= '0;
            state_q <= S_MARK_RD;
          end else begin
            done_q       <= 1'b1;
            status_q     <= ST_NOSPACE;
            start_unit_q <= '0;
            if (pol_q == POL_NEXT) begin
              next_ptr_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        S_MARK_RD: begin
          // words wholly below the run are stepped over
          if ((wbase_q + POS_W'(WORD_BITS)) > POS_W'(grant_q)) begin
            state_q <= S_MARK_WR;
          end else begin
            word_q  <= word_q + 1'b1;
            wbase_q <= wbase_q + POS_W'(WORD_BITS);
          end
        end
        S_MARK_WR: begin
          if ((wbase_q + POS_W'(WORD_BITS)) >= end_q) begin
            done_q       <= 1'b1;
            status_q     <= ST_ALLOC;
            start_unit_q <= START_W'(grant_q);
            state_q      <= S_IDLE;
          end else begin
            word_q  <= word_q + 1'b1;
            wbase_q <= wbase_q + POS_W'(WORD_BITS);
            state_q <= S_MARK_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign start_unit_o = start_unit_q;

  // a result is only ever shown once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while a request is still in work");

  // a load answers in the next cycle
  a_load_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load) |=> (done_o && (status_o == ST_LOADED)))
    else $error("load request not answered in the next cycle");

  // a zero size allocate request answers no space, with start unit zero, without a search
  a_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_load && (alloc_size_i == '0)) |=>
      (done_o && (status_o == ST_NOSPACE) && (start_unit_o == '0)))
    else $error("zero size request not refused");

  // the write-back pass only writes words that were just read
  a_mark_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK_WR) |-> $past(mem_req.re))
    else $error("write-back without a preceding read");

endmodule
